// ===== rtl/bcpl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the battery charge lookup: widths, register and chemistry codes,
// per-cell voltage curves and the payload structs passed between pipeline stages.
// No dependencies.
package bcpl_pkg;

    localparam int MV_W         = 16;  // pack voltage in millivolts
    localparam int PCT_W        = 7;   // charge percent
    localparam int CELLS_W      = 4;
    localparam int CHEM_W       = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 4;
    localparam int TABLE_POINTS = 10;
    localparam int PT_W         = 13;  // one per-cell curve point, up to 4200 mV
    localparam int REM_W        = 20;  // 10 * (v - lo) fits in 20 bits
    localparam int QUO_W        = 4;   // fraction 0 .. 10
    localparam int BASE_W       = 8;   // 10 * segment index, before saturation

    localparam logic [BASE_W-1:0] PCT_FULL  = 8'd100;
    localparam logic [BASE_W-1:0] PCT_EMPTY = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELL_COUNT     = 1'b0,
        REG_CELL_CHEMISTRY = 1'b1
    } t_cfg_reg;

    localparam logic [CHEM_W-1:0] CHEM_NONE = 2'd0;
    localparam logic [CHEM_W-1:0] CHEM_LIPO = 2'd1;
    localparam logic [CHEM_W-1:0] CHEM_LFP  = 2'd2;

    localparam logic [PT_W-1:0] LIPO_CURVE [TABLE_POINTS] = '{
        13'd3600, 13'd3700, 13'd3750, 13'd3790, 13'd3830,
        13'd3870, 13'd3920, 13'd3970, 13'd4100, 13'd4200
    };
    localparam logic [PT_W-1:0] LFP_CURVE [TABLE_POINTS] = '{
        13'd3218, 13'd3257, 13'd3272, 13'd3277, 13'd3282,
        13'd3302, 13'd3318, 13'd3322, 13'd3324, 13'd3558
    };

    // Curve points past the end of the table repeat the last point.
    function automatic logic [PT_W-1:0] curve_mv(input logic use_lfp, input int idx);
        int k;
        k = (idx >= TABLE_POINTS) ? TABLE_POINTS - 1 : idx;
        return use_lfp ? LFP_CURVE[k] : LIPO_CURVE[k];
    endfunction

    typedef struct packed {
        logic [MV_W-1:0]   v;
        logic [MV_W-1:0]   lo;
        logic [MV_W-1:0]   hi;
        logic [BASE_W-1:0] base;
        logic              bypass;
    } t_sel;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [MV_W-1:0]   span;
        logic [QUO_W-1:0]  quo;
        logic [BASE_W-1:0] base;
        logic              bypass;
    } t_div;

endpackage

// ===== rtl/bcpl_in_if.sv =====
`timescale 1ns / 1ps
// Input channel carrying one pack voltage sample per transaction.
// Depends on bcpl_pkg.
interface bcpl_in_if;
    logic                        valid;
    logic                        ready;
    logic [bcpl_pkg::MV_W-1:0]   pack_millivolts;

    modport source (output valid, output pack_millivolts, input ready);
    modport sink   (input valid, input pack_millivolts, output ready);
endinterface

// ===== rtl/bcpl_out_if.sv =====
`timescale 1ns / 1ps
// Output channel carrying one charge estimate per transaction.
// Depends on bcpl_pkg.
interface bcpl_out_if;
    logic                        valid;
    logic                        ready;
    logic [bcpl_pkg::PCT_W-1:0]  charge_percent;

    modport source (output valid, output charge_percent, input ready);
    modport sink   (input valid, input charge_percent, output ready);
endinterface

// ===== rtl/bcpl_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on bcpl_pkg.
interface bcpl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bcpl_pkg::CFG_IDX_W-1:0]   index;
    logic [bcpl_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bcpl_scale.sv =====
`timescale 1ns / 1ps
// First pipeline stage: scale the per-cell curve by the cell count.
// Depends on bcpl_pkg.
module bcpl_scale #(
    parameter int CURVE_POINTS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [bcpl_pkg::MV_W-1:0]       i_mv,
    input  logic [bcpl_pkg::CELLS_W-1:0]    i_cells,
    input  logic [bcpl_pkg::CHEM_W-1:0]     i_chem,
    output logic                            o_valid,
    output logic [bcpl_pkg::MV_W-1:0]       o_mv,
    output logic [bcpl_pkg::MV_W-1:0]       o_pts [CURVE_POINTS],
    output logic                            o_zero
);
    logic                      r_valid;
    logic [bcpl_pkg::MV_W-1:0] r_mv;
    logic [bcpl_pkg::MV_W-1:0] r_pts [CURVE_POINTS];
    logic                      r_zero;
    logic [bcpl_pkg::MV_W-1:0] n_pts [CURVE_POINTS];
    logic                      n_zero;
    logic                      use_lfp;

    assign use_lfp = (i_chem == bcpl_pkg::CHEM_LFP);
    assign n_zero  = (i_cells == '0) || (i_chem == bcpl_pkg::CHEM_NONE);

    always_comb begin
        for (int k = 0; k < CURVE_POINTS; k++) begin
            n_pts[k] = bcpl_pkg::MV_W'(bcpl_pkg::curve_mv(use_lfp, k))
                     * bcpl_pkg::MV_W'(i_cells);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mv   <= i_mv;
            r_pts  <= n_pts;
            r_zero <= n_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_mv    = r_mv;
    assign o_pts   = r_pts;
    assign o_zero  = r_zero;
endmodule

// ===== rtl/bcpl_select.sv =====
`timescale 1ns / 1ps
// Second pipeline stage: locate the curve segment holding the voltage.
// Depends on bcpl_pkg.
module bcpl_select #(
    parameter int CURVE_POINTS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [bcpl_pkg::MV_W-1:0]   i_mv,
    input  logic [bcpl_pkg::MV_W-1:0]   i_pts [CURVE_POINTS],
    input  logic                        i_zero,
    output logic                        o_valid,
    output bcpl_pkg::t_sel              o_sel
);
    localparam int IDX_W = $clog2(CURVE_POINTS);

    logic              r_valid;
    bcpl_pkg::t_sel    r_sel;
    bcpl_pkg::t_sel    n_sel;
    logic [IDX_W-1:0]  seg;

    always_comb begin
        seg      = IDX_W'(CURVE_POINTS - 1);
        n_sel.v  = i_mv;
        n_sel.lo = i_pts[CURVE_POINTS-2];
        n_sel.hi = i_pts[CURVE_POINTS-1];
        // Highest index first so the lowest matching point wins.
        for (int k = CURVE_POINTS - 1; k >= 1; k--) begin
            if (i_mv <= i_pts[k]) begin
                seg      = IDX_W'(k);
                n_sel.lo = i_pts[k-1];
                n_sel.hi = i_pts[k];
            end
        end
        n_sel.base   = (bcpl_pkg::BASE_W'(seg) << 3) + (bcpl_pkg::BASE_W'(seg) << 1);
        n_sel.bypass = 1'b0;
        if (i_zero || (i_mv < i_pts[0])) begin
            n_sel.base   = bcpl_pkg::PCT_EMPTY;
            n_sel.bypass = 1'b1;
        end else if (i_mv >= i_pts[CURVE_POINTS-1]) begin
            n_sel.base   = bcpl_pkg::PCT_FULL;
            n_sel.bypass = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel <= n_sel;
        end
    end

    assign o_valid = r_valid;
    assign o_sel   = r_sel;
endmodule

// ===== rtl/bcpl_divstage.sv =====
`timescale 1ns / 1ps
// Restoring divider stage: resolve two quotient bits, FIRST_BIT and the one below.
// Depends on bcpl_pkg.
module bcpl_divstage #(
    parameter int FIRST_BIT = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  bcpl_pkg::t_div  i_div,
    output logic            o_valid,
    output bcpl_pkg::t_div  o_div
);
    logic            r_valid;
    bcpl_pkg::t_div  r_div;
    bcpl_pkg::t_div  n_div;
    logic [bcpl_pkg::REM_W-1:0] trial;

    always_comb begin
        n_div = i_div;
        trial = '0;
        for (int s = 0; s < 2; s++) begin
            trial = bcpl_pkg::REM_W'(i_div.span) << (FIRST_BIT - s);
            if (n_div.rem >= trial) begin
                n_div.rem                = n_div.rem - trial;
                n_div.quo[FIRST_BIT - s] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
endmodule

// ===== rtl/battery_charge_percent_lookup.sv =====
`timescale 1ns / 1ps
// Top level of the battery charge lookup: config registers, pipeline and output stage.
// Depends on bcpl_pkg, the channel interfaces, bcpl_scale, bcpl_select, bcpl_divstage.
//
//  Channel   Direction  Payload                    Meaning
//  i_pack    in         pack_millivolts [15:0]     pack voltage sample, mV
//  o_charge  out        charge_percent [6:0]       charge estimate, 0 .. 100
//  i_cfg     in         index [0], data [3:0]      0: cell count, 1: chemistry
//
// One transaction enters per cycle while the input is ready; each passes to the output
// register through curve scaling, segment search, span/numerator, then two divider
// stages of two quotient bits each; the output register adds the fraction and saturates.
// Reset clears the stage valid bits and both config registers; there is no clearing pass.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// collapse under a stall and the input keeps accepting while any stage has room.
module battery_charge_percent_lookup #(
    parameter int CURVE_POINTS = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bcpl_in_if.sink      i_pack,
    bcpl_out_if.source   o_charge,
    bcpl_cfg_if.sink     i_cfg
);
    // Configuration registers.
    logic [bcpl_pkg::CELLS_W-1:0] r_cell_count;
    logic [bcpl_pkg::CHEM_W-1:0]  r_cell_chemistry;

    // Stage enables, from the output back to the input.
    logic en_s1, en_s2, en_s3, en_s4, en_s5;

    logic                      s1_valid;
    logic [bcpl_pkg::MV_W-1:0] s1_mv;
    logic [bcpl_pkg::MV_W-1:0] s1_pts [CURVE_POINTS];
    logic                      s1_zero;

    logic                      s2_valid;
    bcpl_pkg::t_sel            s2_sel;

    logic                      r_s3_valid;
    bcpl_pkg::t_div            r_s3_div;
    bcpl_pkg::t_div            n_s3_div;

    logic                      s4_valid;
    bcpl_pkg::t_div            s4_div;
    logic                      s5_valid;
    bcpl_pkg::t_div            s5_div;

    logic                      r_out_valid;
    logic [bcpl_pkg::PCT_W-1:0] r_out_pct;
    logic [bcpl_pkg::BASE_W-1:0] n_sum;
    logic [bcpl_pkg::PCT_W-1:0] n_out_pct;

    // Config writes are always taken; write data is masked to the register width.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count     <= '0;
            r_cell_chemistry <= bcpl_pkg::CHEM_NONE;
        end else if (i_cfg.valid) begin
            unique case (bcpl_pkg::t_cfg_reg'(i_cfg.index))
                bcpl_pkg::REG_CELL_COUNT: begin
                    r_cell_count <= i_cfg.data[bcpl_pkg::CELLS_W-1:0];
                end
                bcpl_pkg::REG_CELL_CHEMISTRY: begin
                    r_cell_chemistry <= i_cfg.data[bcpl_pkg::CHEM_W-1:0];
                end
            endcase
        end
    end

    // Handshake: each stage loads when empty or when its successor loads.
    assign en_s5 = !r_out_valid || o_charge.ready;
    assign en_s4 = !s5_valid    || en_s5;
    assign en_s3 = !s4_valid    || en_s4;
    assign en_s2 = !r_s3_valid  || en_s3;
    assign en_s1 = !s2_valid    || en_s2;
    assign i_pack.ready = !s1_valid || en_s1;

    // Stage 1: scale the curve by the cell count.
    bcpl_scale #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_pack.ready),
        .i_valid (i_pack.valid),
        .i_mv    (i_pack.pack_millivolts),
        .i_cells (r_cell_count),
        .i_chem  (r_cell_chemistry),
        .o_valid (s1_valid),
        .o_mv    (s1_mv),
        .o_pts   (s1_pts),
        .o_zero  (s1_zero)
    );

    // Stage 2: pick the segment, or decide empty / full outright.
    bcpl_select #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_s1),
        .i_valid (s1_valid),
        .i_mv    (s1_mv),
        .i_pts   (s1_pts),
        .i_zero  (s1_zero),
        .o_valid (s2_valid),
        .o_sel   (s2_sel)
    );

    // Stage 3: numerator 10 * (v - lo) and segment span. A flat segment
    // contributes no fraction, so bypass the divider for it.
    always_comb begin
        n_s3_div.rem    = (bcpl_pkg::REM_W'(s2_sel.v - s2_sel.lo) << 3)
                        + (bcpl_pkg::REM_W'(s2_sel.v - s2_sel.lo) << 1);
        n_s3_div.span   = s2_sel.hi - s2_sel.lo;
        n_s3_div.quo    = '0;
        n_s3_div.base   = s2_sel.base;
        n_s3_div.bypass = s2_sel.bypass || (s2_sel.hi == s2_sel.lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en_s2) begin
            r_s3_valid <= s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s2) begin
            r_s3_div <= n_s3_div;
        end
    end

    // Stages 4 and 5: quotient bits 3..2, then 1..0.
    bcpl_divstage #(
        .FIRST_BIT (3)
    ) u_div_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_s3),
        .i_valid (r_s3_valid),
        .i_div   (r_s3_div),
        .o_valid (s4_valid),
        .o_div   (s4_div)
    );

    bcpl_divstage #(
        .FIRST_BIT (1)
    ) u_div_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_s4),
        .i_valid (s4_valid),
        .i_div   (s4_div),
        .o_valid (s5_valid),
        .o_div   (s5_div)
    );

    // Output register: add the fraction to the segment base and clamp at full.
    always_comb begin
        n_sum = s5_div.bypass ? s5_div.base
                              : s5_div.base + bcpl_pkg::BASE_W'(s5_div.quo);
        n_out_pct = (n_sum > bcpl_pkg::PCT_FULL) ? bcpl_pkg::PCT_W'(bcpl_pkg::PCT_FULL)
                                                 : n_sum[bcpl_pkg::PCT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_s5) begin
            r_out_valid <= s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s5) begin
            r_out_pct <= n_out_pct;
        end
    end

    assign o_charge.valid          = r_out_valid;
    assign o_charge.charge_percent = r_out_pct;

    // Result never exceeds full charge.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_charge.valid |-> (o_charge.charge_percent <= bcpl_pkg::PCT_W'(bcpl_pkg::PCT_FULL)))
        else $error("charge_percent above 100");

    // Input back-pressure only when every stage holds a transaction and the output stalls.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pack.ready |-> (s1_valid && s2_valid && r_s3_valid && s4_valid && s5_valid
                           && r_out_valid && !o_charge.ready))
        else $error("input stalled while pipeline has room");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_charge.valid && !s1_valid && !r_s3_valid))
        else $error("pipeline not empty after reset");

    // A flat or decided segment carries a zero quotient out of stage 3.
    a_bypass_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && r_s3_div.bypass) |-> (r_s3_div.quo == '0))
        else $error("bypassed transaction carries a quotient");
endmodule
